// ===== rtl/ilp_pkg.sv =====
// shared types, constants and character decode functions for the literal parser
package ilp_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 64;
    localparam int CHAR_WIDTH          = 8;
    localparam int RADIX_WIDTH         = 5;
    localparam int DIGIT_WIDTH         = 5;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [RADIX_WIDTH-1:0] RADIX_BIN  = 5'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_OCT  = 5'd8;
    localparam logic [RADIX_WIDTH-1:0] RADIX_DEC  = 5'd10;
    localparam logic [RADIX_WIDTH-1:0] RADIX_DUO  = 5'd12;
    localparam logic [RADIX_WIDTH-1:0] RADIX_HEX  = 5'd16;
    localparam logic [RADIX_WIDTH-1:0] RADIX_NONE = 5'd0;

    localparam logic [DIGIT_WIDTH-1:0] NOT_A_DIGIT = 5'd16;

    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_WIDTH-1:0] CH_UNDER = 8'h5f;
    localparam logic [CHAR_WIDTH-1:0] CH_B     = 8'h62;
    localparam logic [CHAR_WIDTH-1:0] CH_O     = 8'h6f;
    localparam logic [CHAR_WIDTH-1:0] CH_D     = 8'h64;
    localparam logic [CHAR_WIDTH-1:0] CH_Z     = 8'h7a;
    localparam logic [CHAR_WIDTH-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_H     = 8'h68;

    typedef enum logic [1:0] {
        OP_DIGIT,
        OP_SKIP,
        OP_PREFIX
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [RADIX_WIDTH-1:0] radix;
        logic [DIGIT_WIDTH-1:0] digit;
        logic                   last;
    } t_cmd;

    function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
        logic [CHAR_WIDTH-1:0] d;
        begin
            d = CHAR_WIDTH'(NOT_A_DIGIT);
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
            end else if (c >= CH_LA && c <= CH_LF) begin
                d = c - CH_LA + 8'd10;
            end else if (c >= CH_UA && c <= CH_UF) begin
                d = c - CH_UA + 8'd10;
            end
            return d[DIGIT_WIDTH-1:0];
        end
    endfunction

    function automatic logic [RADIX_WIDTH-1:0] prefix_radix(input logic [CHAR_WIDTH-1:0] c);
        logic [RADIX_WIDTH-1:0] r;
        begin
            unique case (c)
                CH_B:       r = RADIX_BIN;
                CH_O:       r = RADIX_OCT;
                CH_D:       r = RADIX_DEC;
                CH_Z:       r = RADIX_DUO;
                CH_X, CH_H: r = RADIX_HEX;
                default:    r = RADIX_NONE;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/ilp_front.sv =====
// front end: tracks position in the literal and classifies each character
module ilp_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [ilp_pkg::CHAR_WIDTH-1:0] i_char,
    input  logic                           i_last,
    output logic                           o_ready,
    output logic                           o_push,
    output ilp_pkg::t_cmd                  o_cmd,
    input  logic                           i_queue_ready
);
    import ilp_pkg::*;

    logic [1:0]             r_pos;
    logic [1:0]             n_pos;
    logic                   r_lz;
    logic                   n_lz;
    logic [RADIX_WIDTH-1:0] pr;
    logic                   take;

    assign o_ready = i_queue_ready;
    assign take    = i_valid && i_queue_ready;
    assign o_push  = take;
    assign pr      = prefix_radix(i_char);

    always_comb begin
        o_cmd.radix = pr;
        o_cmd.digit = digit_of(i_char);
        o_cmd.last  = i_last;
        if (r_pos == 2'd1 && r_lz && pr != RADIX_NONE) begin
            o_cmd.op = OP_PREFIX;
        end else if (i_char == CH_UNDER) begin
            o_cmd.op = OP_SKIP;
        end else begin
            o_cmd.op = OP_DIGIT;
        end
    end

    always_comb begin
        n_pos = r_pos;
        n_lz  = r_lz;
        if (take) begin
            if (r_pos == 2'd0) begin
                n_lz = (i_char == CH_ZERO);
            end
            if (r_pos != 2'd2) begin
                n_pos = r_pos + 2'd1;
            end
            // a new literal starts after the last character
            if (i_last) begin
                n_pos = 2'd0;
                n_lz  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
            r_lz  <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_lz  <= n_lz;
        end
    end

endmodule

// ===== rtl/ilp_queue.sv =====
// short command queue between the front end and the accumulator
module ilp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ilp_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output ilp_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import ilp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_cnt != CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_entry[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/ilp_back.sv =====
// back end: radix, halt flag, multiply-accumulate and output register
module ilp_back #(
    parameter int VALUE_WIDTH = ilp_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  ilp_pkg::t_cmd          i_cmd,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [VALUE_WIDTH-1:0] o_value,
    input  logic                   i_ready
);
    import ilp_pkg::*;

    logic [RADIX_WIDTH-1:0] r_radix;
    logic [RADIX_WIDTH-1:0] n_radix;
    logic                   r_halted;
    logic                   n_halted;
    logic [VALUE_WIDTH-1:0] r_acc;
    logic [VALUE_WIDTH-1:0] n_acc;
    logic [VALUE_WIDTH-1:0] scaled;
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic                   can_take;

    // a last character needs room in the output register
    assign can_take = !i_cmd.last || !r_out_valid || i_ready;
    assign o_pop    = i_valid && can_take;
    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;

    // small radix multiply as shift-and-add
    always_comb begin
        case (r_radix)
            RADIX_BIN: scaled = r_acc << 1;
            RADIX_OCT: scaled = r_acc << 3;
            RADIX_DUO: scaled = (r_acc << 3) + (r_acc << 2);
            RADIX_HEX: scaled = r_acc << 4;
            default:   scaled = (r_acc << 3) + (r_acc << 1);
        endcase
    end

    always_comb begin
        n_radix  = r_radix;
        n_halted = r_halted;
        n_acc    = r_acc;
        case (i_cmd.op)
            OP_PREFIX: begin
                n_radix = i_cmd.radix;
                n_acc   = '0;
            end
            OP_DIGIT: begin
                if (!r_halted) begin
                    if (i_cmd.digit >= r_radix) begin
                        n_halted = 1'b1;
                    end else begin
                        n_acc = scaled + VALUE_WIDTH'(i_cmd.digit);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.last) begin
            r_out_value <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= RADIX_DEC;
            r_halted    <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_cmd.last) begin
                    r_radix     <= RADIX_DEC;
                    r_halted    <= 1'b0;
                    r_acc       <= '0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_radix  <= n_radix;
                    r_halted <= n_halted;
                    r_acc    <= n_acc;
                    if (i_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/integer_literal_parser.sv =====
// integer literal parser top level: stream in characters, stream out values
//
// input stream: one ascii character per transaction on s_axis_tdata, with
// s_axis_tlast high on the final character of a literal. a leading '0' may be
// followed by a base prefix (b, o, d, z, x, h); underscores are skipped and
// the first character that is not a digit of the base freezes the value.
// output stream: one transaction per literal on m_axis_tdata carrying the
// value modulo 2^VALUE_WIDTH, zero padded to whole bytes.
// throughput: one character per cycle while the receiver does not stall, set
// by the single shift-and-add accumulate step in the back end.
// the last character of a literal is taken into the command queue, and its
// value is then presented from the output register.
// reset (synchronous, active low) empties the queue and output register and
// restarts parsing at the first character of a literal.
// when the receiver stalls the value holds in the output register; the back end
// keeps consuming characters up to the next last one, which waits in the queue;
// the queue then fills and s_axis_tready drops.
module integer_literal_parser #(
    parameter int VALUE_WIDTH = ilp_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [ilp_pkg::CHAR_WIDTH-1:0]       s_axis_tdata,  // [7:0] char_code
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]     m_axis_tdata   // value, zero padded
);
    import ilp_pkg::*;

    localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    logic                   push;
    t_cmd                   front_cmd;
    logic                   q_ready;
    logic                   q_valid;
    t_cmd                   q_cmd;
    logic                   pop;
    logic [VALUE_WIDTH-1:0] value;

    ilp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .i_char        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .o_ready       (s_axis_tready),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .i_queue_ready (q_ready)
    );

    ilp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    ilp_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_value (value),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = TDATA_W'(value);

endmodule
